// File: hw/rtl/lzssd_pkg.sv
package lzssd_pkg;

	// Parse phase of the byte-driven parser
	typedef enum logic [3:0] {
		PH_START    = 4'd0,
		PH_GOT0     = 4'd1,
		PH_CNT1     = 4'd2,
		PH_CNT2     = 4'd3,
		PH_LIT      = 4'd4,
		PH_INL_DIST = 4'd5,
		PH_SH_LO    = 4'd6,
		PH_SH_HI    = 4'd7,
		PH_LONG_LEN = 4'd8
	} phase_t;

	// Sequencer states
	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_BITS,
		SQ_READ,
		SQ_PUT,
		SQ_END
	} seq_t;

	// Descriptor bookkeeping
	localparam logic [4:0] DESC_EMPTY   = 5'd0;
	localparam logic [4:0] DESC_FULL    = 5'd16;
	localparam logic [4:0] DESC_HI_WAIT = 5'd31;

	// Results reported per input byte
	localparam logic [5:0] MAX_RESULTS = 6'd32;
	localparam logic [5:0] LAST_RESULT = 6'd31;

	localparam int DIST_W = 14;

	// Long match length byte codes
	localparam logic [7:0] LEN_END  = 8'd0;
	localparam logic [7:0] LEN_SKIP = 8'd1;

	// Window access request from the sequencer
	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [7:0]        wdata;
		logic [DIST_W-1:0] back_dist;
	} win_ctl_t;

endpackage

// File: hw/rtl/lzssd_ram.sv
module lzssd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/lzssd_window.sv
module lzssd_window #(
	parameter int WINDOW_DEPTH = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lzssd_pkg::win_ctl_t ctl,
	output logic [7:0]          rd_byte
);
	import lzssd_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [AW-1:0] wp_q;
	logic          full_q;
	logic [AW:0]   diff;
	logic [AW-1:0] src;
	logic          src_ok;
	logic          ok_q;
	logic [7:0]    ram_data;

	// Source address: write pointer minus distance, wrapped into the window
	assign diff   = {1'b0, wp_q} - (AW+1)'(ctl.back_dist);
	assign src    = diff[AW] ? AW'(diff + (AW+1)'(WINDOW_DEPTH)) : diff[AW-1:0];
	// Entries not yet written since reset read as zero
	assign src_ok = full_q || !diff[AW];

	// Write pointer, fill flag and read-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
			ok_q   <= 1'b0;
		end else begin
			if (ctl.wr) begin
				if (wp_q == AW'(WINDOW_DEPTH - 1)) begin
					wp_q   <= '0;
					full_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
			if (ctl.rd) begin
				ok_q <= src_ok;
			end
		end
	end

	lzssd_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ctl.wr),
		.wr_addr (wp_q),
		.wr_data (ctl.wdata),
		.rd_en   (ctl.rd),
		.rd_addr (src),
		.rd_data (ram_data)
	);

	assign rd_byte = ok_q ? ram_data : 8'h00;

endmodule

// File: hw/rtl/lzss_descriptor_stream_decompressor_unit.sv
// Channel | Dir | Signals                        | Payload
// s_*     | in  | s_tvalid s_tready s_tdata[7:0] | comp_byte
// m_*     | out | m_tvalid m_tready m_tdata[71:0]| out_bytes, byte_count
//         |     | m_tlast m_tuser                | last_of_run, end_of_stream
// A descriptor low byte is only stored. A descriptor high byte or a parameter byte then leads
// to the bit state, one descriptor bit per cycle (up to 16 bits), and back to idle.
// Each match byte passes through the window RAM as a registered read, then a write; a literal
// byte needs only the write. After the last byte of a code, the descriptor bits are walked.
// Reset needs no clearing pass: a fill flag makes unwritten window entries read as zero.
// A full output register stalls the sequencer only when a result must be delivered.
module lzss_descriptor_stream_decompressor_unit #(
	parameter int WINDOW_DEPTH     = 8192,
	parameter int BYTES_PER_RESULT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] comp_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] out_bytes, [67:64] byte_count, [71:68] zero
	output logic        m_tlast,   // last_of_run
	output logic        m_tuser    // end_of_stream
);
	import lzssd_pkg::*;

	seq_t              state_q, state_d;
	phase_t            phase_q;
	logic [4:0]        bits_q;
	logic [15:0]       desc_q;
	logic [7:0]        lo_q;
	logic [7:0]        hi_q;
	logic [7:0]        lit_q;
	logic              is_lit_q;
	logic [DIST_W-1:0] dist_q;
	logic [8:0]        len_q;
	logic [63:0]       acc_q;
	logic [3:0]        fill_q;
	logic [5:0]        rcnt_q;

	logic [63:0] out_bytes_q;
	logic [3:0]  out_cnt_q;
	logic        out_last_q;
	logic        out_eos_q;
	logic        out_valid_q;

	logic        in_req;
	logic        out_free;
	logic        bit_go;
	logic        put_flush;
	logic        need_out;
	logic        put_go;
	logic        end_go;
	logic [7:0]  new_byte;
	logic [7:0]  rd_byte;
	logic [63:0] acc_new;
	win_ctl_t    win_ctl;

	assign in_req   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign new_byte = is_lit_q ? lit_q : rd_byte;
	assign acc_new  = acc_q | (64'(new_byte) << {fill_q[2:0], 3'b000});

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (in_req) begin
					if (bits_q == DESC_EMPTY) begin
						state_d = SQ_IDLE;
					end else if (bits_q > DESC_FULL) begin
						state_d = SQ_BITS;
					end else begin
						case (phase_q)
							PH_LIT:      state_d = SQ_PUT;
							PH_INL_DIST: state_d = SQ_READ;
							PH_SH_HI:    state_d = (s_tdata[2:0] != 3'd0) ? SQ_READ : SQ_BITS;
							PH_LONG_LEN: begin
								if (s_tdata == LEN_END) begin
									state_d = SQ_END;
								end else if (s_tdata == LEN_SKIP) begin
									state_d = SQ_BITS;
								end else begin
									state_d = SQ_READ;
								end
							end
							default:     state_d = SQ_BITS;
						endcase
					end
				end
			end
			SQ_BITS: state_d = bit_go ? SQ_BITS : SQ_IDLE;
			SQ_READ: state_d = SQ_PUT;
			SQ_PUT: begin
				if (put_go) begin
					state_d = (len_q == 9'd1) ? SQ_BITS : SQ_READ;
				end
			end
			SQ_END:  state_d = end_go ? SQ_IDLE : SQ_END;
			default: state_d = SQ_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready  = (state_q == SQ_IDLE);
		bit_go    = (state_q == SQ_BITS) && (phase_q <= PH_CNT2) &&
		            (bits_q != DESC_EMPTY) && (bits_q <= DESC_FULL);
		put_flush = (fill_q + 4'd1 == 4'(BYTES_PER_RESULT)) || (len_q == 9'd1);
		need_out  = put_flush && (rcnt_q < MAX_RESULTS);
		put_go    = (state_q == SQ_PUT) && (!need_out || out_free);
		end_go    = (state_q == SQ_END) && out_free;
		win_ctl.rd        = (state_q == SQ_READ);
		win_ctl.wr        = put_go;
		win_ctl.wdata     = new_byte;
		win_ctl.back_dist = dist_q;
	end

	// Parser, descriptor and copy registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SQ_IDLE;
			phase_q  <= PH_START;
			bits_q   <= DESC_EMPTY;
			desc_q   <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			lit_q    <= '0;
			is_lit_q <= 1'b0;
			dist_q   <= '0;
			len_q    <= '0;
			fill_q   <= '0;
			rcnt_q   <= '0;
			acc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (in_req) begin
				rcnt_q <= '0;
				fill_q <= '0;
				acc_q  <= '0;
				if (bits_q == DESC_EMPTY) begin
					lo_q   <= s_tdata;
					bits_q <= DESC_HI_WAIT;
				end else if (bits_q > DESC_FULL) begin
					desc_q <= {s_tdata, lo_q};
					bits_q <= DESC_FULL;
				end else begin
					case (phase_q)
						PH_LIT: begin
							lit_q    <= s_tdata;
							is_lit_q <= 1'b1;
							len_q    <= 9'd1;
							phase_q  <= PH_START;
						end
						PH_INL_DIST: begin
							dist_q   <= DIST_W'(9'h100 - {1'b0, s_tdata});
							len_q    <= 9'(hi_q[1:0]) + 9'd2;
							is_lit_q <= 1'b0;
							phase_q  <= PH_START;
						end
						PH_SH_LO: begin
							lo_q    <= s_tdata;
							phase_q <= PH_SH_HI;
						end
						PH_SH_HI: begin
							hi_q <= s_tdata;
							if (s_tdata[2:0] != 3'd0) begin
								dist_q   <= 14'h2000 - {1'b0, s_tdata[7:3], lo_q};
								len_q    <= 9'(s_tdata[2:0]) + 9'd2;
								is_lit_q <= 1'b0;
								phase_q  <= PH_START;
							end else begin
								phase_q <= PH_LONG_LEN;
							end
						end
						PH_LONG_LEN: begin
							if (s_tdata != LEN_END) begin
								dist_q   <= 14'h2000 - {1'b0, hi_q[7:3], lo_q};
								len_q    <= 9'(s_tdata) + 9'd1;
								is_lit_q <= 1'b0;
								phase_q  <= PH_START;
							end
						end
						default: phase_q <= PH_START;
					endcase
				end
			end
			// One descriptor bit per cycle
			if (bit_go) begin
				desc_q <= desc_q >> 1;
				bits_q <= bits_q - 5'd1;
				case (phase_q)
					PH_START: phase_q <= desc_q[0] ? PH_LIT : PH_GOT0;
					PH_GOT0:  phase_q <= desc_q[0] ? PH_SH_LO : PH_CNT1;
					PH_CNT1: begin
						hi_q    <= {7'd0, desc_q[0]};
						phase_q <= PH_CNT2;
					end
					default: begin
						hi_q    <= {6'd0, hi_q[0], desc_q[0]};
						phase_q <= PH_INL_DIST;
					end
				endcase
			end
			// One decoded byte per put
			if (put_go) begin
				len_q <= len_q - 9'd1;
				if (put_flush) begin
					fill_q <= '0;
					acc_q  <= '0;
					if (rcnt_q != MAX_RESULTS) begin
						rcnt_q <= rcnt_q + 6'd1;
					end
				end else begin
					fill_q <= fill_q + 4'd1;
					acc_q  <= acc_new;
				end
			end
			// End marker: drop the descriptor
			if (end_go) begin
				desc_q  <= '0;
				bits_q  <= DESC_EMPTY;
				phase_q <= PH_START;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_bytes_q <= '0;
			out_cnt_q   <= '0;
			out_last_q  <= 1'b0;
			out_eos_q   <= 1'b0;
		end else if (put_go && need_out) begin
			out_valid_q <= 1'b1;
			out_bytes_q <= acc_new;
			out_cnt_q   <= fill_q + 4'd1;
			out_last_q  <= (len_q == 9'd1) || (rcnt_q == LAST_RESULT);
			out_eos_q   <= 1'b0;
		end else if (end_go) begin
			out_valid_q <= 1'b1;
			out_bytes_q <= '0;
			out_cnt_q   <= '0;
			out_last_q  <= 1'b1;
			out_eos_q   <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	lzssd_window #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.rd_byte (rd_byte)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_cnt_q, out_bytes_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_eos_q;

	// Checks
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SQ_BITS |-> bits_q <= DESC_FULL)
		else $error("descriptor bit count out of range while parsing");

	a_eos_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[67:64] == 4'd0 && m_tlast))
		else $error("end marker result malformed");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |->
		(m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'(BYTES_PER_RESULT)))
		else $error("data result byte count out of range");

	a_copy_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_READ || state_q == SQ_PUT) |-> len_q != 9'd0)
		else $error("copy running with zero length");

endmodule

// File: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lzssd_pkg::*;

	localparam int WDEPTH = 8192;
	localparam int BPR = 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 600;

	typedef struct packed {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic        last;
		logic        eos;
	} decoded_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	lzss_descriptor_stream_decompressor_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Decoder shadow state
	logic [7:0]  hist [WDEPTH];
	logic [12:0] wptr;
	logic [15:0] dshift;
	logic [4:0]  dleft;
	phase_t      phase;
	logic [7:0]  lo_byte;
	logic [7:0]  hi_byte;

	decoded_t    expected_q[$];
	logic [7:0]  comp_q[$];
	decoded_t    batch[$];
	logic [63:0] acc;
	int          fill;

	int errors = 0;
	int sent = 0;
	int got = 0;
	int eos_seen = 0;
	int snd_idle = 26;
	int rcv_idle = 52;
	int quiet = 0;

	function automatic void flush_group();
		decoded_t r;
		if (batch.size() < 32) begin
			r.bytes = acc;
			r.count = fill[3:0];
			r.last = 1'b0;
			r.eos = 1'b0;
			batch.push_back(r);
		end
		acc = '0;
		fill = 0;
	endfunction

	function automatic void emit_byte(logic [7:0] b);
		hist[wptr] = b;
		wptr = wptr + 13'd1;
		acc = acc | (64'(b) << (8 * fill));
		fill++;
		if (fill >= BPR)
			flush_group();
	endfunction

	function automatic void copy_back(int offs, int len);
		for (int i = 0; i < len; i++)
			emit_byte(hist[13'(int'(wptr) + WDEPTH - offs)]);
	endfunction

	// Consume descriptor bits until the parser needs a byte
	function automatic void walk_bits();
		logic b;
		while (phase <= PH_CNT2 && dleft >= 5'd1 && dleft <= DESC_FULL) begin
			b = dshift[0];
			dshift = dshift >> 1;
			dleft = dleft - 5'd1;
			case (phase)
				PH_START: phase = b ? PH_LIT : PH_GOT0;
				PH_GOT0:  phase = b ? PH_SH_LO : PH_CNT1;
				PH_CNT1: begin
					hi_byte = {7'd0, b};
					phase = PH_CNT2;
				end
				default: begin
					hi_byte = {6'd0, hi_byte[0], b};
					phase = PH_INL_DIST;
				end
			endcase
		end
	endfunction

	function automatic void decode_byte(logic [7:0] c);
		decoded_t r;
		batch = {};
		acc = '0;
		fill = 0;
		if (dleft == DESC_EMPTY) begin
			lo_byte = c;
			dleft = DESC_HI_WAIT;
			return;
		end
		if (dleft > DESC_FULL) begin
			dshift = {c, lo_byte};
			dleft = DESC_FULL;
			walk_bits();
			return;
		end
		case (phase)
			PH_LIT: begin
				emit_byte(c);
				phase = PH_START;
			end
			PH_INL_DIST: begin
				copy_back(256 - int'(c), int'(hi_byte[1:0]) + 2);
				phase = PH_START;
			end
			PH_SH_LO: begin
				lo_byte = c;
				phase = PH_SH_HI;
			end
			PH_SH_HI: begin
				hi_byte = c;
				if (c[2:0] != 3'd0) begin
					copy_back(8192 - ((int'(c & 8'hF8) << 5) | int'(lo_byte)),
						int'(c[2:0]) + 2);
					phase = PH_START;
				end else
					phase = PH_LONG_LEN;
			end
			PH_LONG_LEN: begin
				if (c == LEN_END) begin
					if (batch.size() < 32) begin
						r = '0;
						r.eos = 1'b1;
						batch.push_back(r);
					end
					dshift = '0;
					dleft = DESC_EMPTY;
					phase = PH_START;
				end else begin
					if (c != LEN_SKIP)
						copy_back(8192 - ((int'(hi_byte & 8'hF8) << 5) | int'(lo_byte)),
							int'(c) + 1);
					phase = PH_START;
				end
			end
			default: phase = PH_START;
		endcase
		if (fill > 0)
			flush_group();
		walk_bits();
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			expected_q.push_back(batch[i]);
	endfunction

	// Stream building helpers: codes are gathered with their bytes, descriptors packed
	logic [15:0] code_bits;
	int          nbits;
	logic [7:0]  code_bytes[$];

	task automatic put_bit(logic b);
		code_bits[nbits] = b;
		nbits++;
		if (nbits == 16) begin
			comp_q.push_back(code_bits[7:0]);
			comp_q.push_back(code_bits[15:8]);
			foreach (code_bytes[i])
				comp_q.push_back(code_bytes[i]);
			code_bytes = {};
			nbits = 0;
			code_bits = '0;
		end
	endtask

	// A code's bytes follow the descriptor that holds its last bit, or the next
	// descriptor when that bit empties it, so bytes are queued after the bits.
	task automatic add_literal(logic [7:0] v);
		put_bit(1'b1);
		code_bytes.push_back(v);
	endtask

	task automatic add_inline(logic [1:0] cnt, logic [7:0] d);
		put_bit(1'b0);
		put_bit(1'b0);
		put_bit(cnt[1]);
		put_bit(cnt[0]);
		code_bytes.push_back(d);
	endtask

	task automatic add_separate(logic [7:0] l, logic [7:0] h, logic [7:0] n, bit use_n);
		put_bit(1'b0);
		put_bit(1'b1);
		code_bytes.push_back(l);
		code_bytes.push_back(h);
		if (use_n)
			code_bytes.push_back(n);
	endtask

	// Close a stream with the end marker, padding the descriptor with zero bits
	task automatic add_end();
		put_bit(1'b0);
		put_bit(1'b1);
		code_bytes.push_back(8'h00);
		code_bytes.push_back(8'h00);
		code_bytes.push_back(LEN_END);
		do
			put_bit(1'b0);
		while (nbits != 0);
	endtask

	task automatic random_stream(int ncodes);
		int k;
		for (int i = 0; i < ncodes; i++) begin
			k = $urandom_range(0, 9);
			if (k < 4)
				add_literal(8'($urandom));
			else if (k < 6)
				add_inline(2'($urandom), 8'($urandom));
			else if (k < 8)
				add_separate(8'($urandom), {5'($urandom), 3'($urandom_range(1, 7))},
					8'h00, 1'b0);
			else if (k < 9)
				add_separate(8'($urandom), {5'($urandom), 3'd0},
					8'($urandom_range(1, 40)), 1'b1);
			else
				add_separate(8'($urandom), {5'($urandom), 3'd0}, 8'($urandom), 1'b1);
		end
		add_end();
	endtask

	// Driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata);
				sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (comp_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
					s_tvalid <= 1'b1;
					s_tdata <= comp_q.pop_front();
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor and checker
	always @(posedge clk or negedge arst_n) begin
		decoded_t e;
		if (!arst_n)
			m_tready <= 1'b0;
		else begin
			m_tready <= ($urandom_range(0, 99) >= rcv_idle);
			if (m_tvalid && m_tready) begin
				got++;
				if (expected_q.size() == 0) begin
					$error("unexpected result: bytes %h count %0d", m_tdata[63:0], m_tdata[67:64]);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (m_tdata[63:0] !== e.bytes) begin
						$error("out_bytes exp %h got %h", e.bytes, m_tdata[63:0]);
						errors++;
					end
					if (m_tdata[67:64] !== e.count) begin
						$error("byte_count exp %0d got %0d", e.count, m_tdata[67:64]);
						errors++;
					end
					if (m_tlast !== e.last) begin
						$error("last_of_run exp %b got %b", e.last, m_tlast);
						errors++;
					end
					if (m_tuser !== e.eos) begin
						$error("end_of_stream exp %b got %b", e.eos, m_tuser);
						errors++;
					end
					if (e.eos)
						eos_seen++;
				end
			end
		end
	end

	// Watchdog on request traffic
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results pending", expected_q.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		foreach (hist[i])
			hist[i] = '0;
		wptr = '0;
		dshift = '0;
		dleft = DESC_EMPTY;
		phase = PH_START;
		lo_byte = '0;
		hi_byte = '0;
		code_bits = '0;
		nbits = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reads of unwritten window, extremes, skip byte, long match
		add_inline(2'd3, 8'hFF);
		add_literal(8'h00);
		add_literal(8'hFF);
		add_literal(8'hA5);
		add_inline(2'd0, 8'h01);
		add_separate(8'hFF, 8'hFF, 8'h00, 1'b0);
		add_separate(8'h00, 8'h01, 8'h00, 1'b0);
		add_separate(8'hFE, 8'hF8, LEN_SKIP, 1'b1);
		add_separate(8'hFC, 8'hF8, 8'hFF, 1'b1);
		add_separate(8'hFD, 8'hF8, 8'h02, 1'b1);
		add_end();

		// Three idling phases with random streams
		for (int p = 0; p < 3; p++) begin
			random_stream($urandom_range(4, 14));
			while (comp_q.size() > 0 || expected_q.size() > 0 || s_tvalid)
				@(posedge clk);
			if (p == 0) begin
				snd_idle = 52;
				rcv_idle = 26;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
		end
		// Noise: a raw random tail
		repeat (12)
			comp_q.push_back(8'($urandom));
		while (comp_q.size() > 0 || s_tvalid)
			@(posedge clk);
		while (expected_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d compressed bytes, checked %0d results, %0d stream ends",
			sent, got, eos_seen);
		if (errors == 0 && expected_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// File: files.f
hw/rtl/lzssd_pkg.sv
hw/rtl/lzssd_ram.sv
hw/rtl/lzssd_window.sv
hw/rtl/lzss_descriptor_stream_decompressor_unit.sv
tb/tb_top.sv
